// File: rtl/core/rrcs_pkg.sv
// Shared types and constants for the round-robin context scheduler.
`default_nettype none

package rrcs_pkg;

  // Default number of thread slots
  localparam int SLOTS_DEF = 8;

  // Fixed field widths
  localparam int PTR_W     = 32;
  localparam int OUT_IDX_W = 3;

  // Action codes of an input transaction
  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_CREATE = 1'b1;

  // Per-slot thread state
  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2
  } slot_state_t;

  // Control from the sequencer to the slot table
  typedef struct packed {
    logic        state_we;
    slot_state_t state_wdata;
    logic        ptr_we;
    logic        ptr_re;
  } tbl_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/rrcs_table.sv
// Slot table: per-slot state flops and the saved stack pointer memory.
`default_nettype none

module rrcs_table #(
  parameter int SLOTS = rrcs_pkg::SLOTS_DEF,
  localparam int SW   = $clog2(SLOTS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [SW-1:0]                 addr,
  input  wire rrcs_pkg::tbl_ctrl_t           ctrl,
  input  wire logic [rrcs_pkg::PTR_W-1:0]    ptr_wdata,
  output      rrcs_pkg::slot_state_t         state_rdata,
  output      logic [rrcs_pkg::PTR_W-1:0]    ptr_rdata
);

  rrcs_pkg::slot_state_t       state_r [SLOTS];
  logic [rrcs_pkg::PTR_W-1:0]  ptr_mem [SLOTS];
  logic [rrcs_pkg::PTR_W-1:0]  ptr_rdata_r;

  // Hold slot states; slot 0 starts out running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        state_r[i] <= (i == 0) ? rrcs_pkg::ST_RUNNING : rrcs_pkg::ST_UNUSED;
      end
    end else if (ctrl.state_we) begin
      state_r[addr] <= ctrl.state_wdata;
    end
  end

  assign state_rdata = state_r[addr];

  // Write and read the pointer memory, read data registered
  always_ff @(posedge clk) begin
    if (ctrl.ptr_we) begin
      ptr_mem[addr] <= ptr_wdata;
    end
    if (ctrl.ptr_re) begin
      ptr_rdata_r <= ptr_mem[addr];
    end
  end

  assign ptr_rdata = ptr_rdata_r;

endmodule

`default_nettype wire

// File: rtl/core/rrcs_ctrl.sv
// Sequencer: scans the slot table one slot per cycle for create and tick.
`default_nettype none

module rrcs_ctrl #(
  parameter int SLOTS = rrcs_pkg::SLOTS_DEF,
  localparam int SW   = $clog2(SLOTS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input transaction
  input  wire logic                          start,
  input  wire logic                          action,
  input  wire logic [rrcs_pkg::PTR_W-1:0]    stack_pointer,
  output      logic                          idle,
  // slot table
  output      logic [SW-1:0]                 tbl_addr,
  output      rrcs_pkg::tbl_ctrl_t           tbl_ctrl,
  output      logic [rrcs_pkg::PTR_W-1:0]    tbl_wdata,
  input  wire rrcs_pkg::slot_state_t         tbl_state,
  input  wire logic [rrcs_pkg::PTR_W-1:0]    tbl_ptr,
  // result
  output      logic                          res_valid,
  input  wire logic                          res_take,
  output      logic [rrcs_pkg::PTR_W-1:0]    res_ptr,
  output      logic [SW-1:0]                 res_idx,
  output      logic                          res_ok
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SAVE,
    S_SCAN,
    S_PICK,
    S_FETCH,
    S_OUT
  } seq_state_t;

  seq_state_t                  state_r, state_nxt;
  logic                        act_r, act_nxt;
  logic [rrcs_pkg::PTR_W-1:0]  sp_r, sp_nxt;
  logic [SW-1:0]               cur_r, cur_nxt;
  logic [SW-1:0]               idx_r, idx_nxt;
  logic [SW-1:0]               cnt_r, cnt_nxt;
  logic [rrcs_pkg::PTR_W-1:0]  res_ptr_r, res_ptr_nxt;
  logic [SW-1:0]               res_idx_r, res_idx_nxt;
  logic                        res_ok_r, res_ok_nxt;

  logic                        match;
  logic                        last;
  logic [SW-1:0]               idx_inc;

  // Shared scan unit: compare the slot state, step the index with wrap
  always_comb begin
    if (act_r == rrcs_pkg::ACT_CREATE) begin
      match = (tbl_state == rrcs_pkg::ST_UNUSED);
    end else begin
      match = (tbl_state == rrcs_pkg::ST_READY);
    end
    last    = (cnt_r == SW'(SLOTS - 1));
    idx_inc = (idx_r == SW'(SLOTS - 1)) ? '0 : idx_r + SW'(1);
  end

  // Next state, table control and result capture
  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    sp_nxt      = sp_r;
    cur_nxt     = cur_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    res_ptr_nxt = res_ptr_r;
    res_idx_nxt = res_idx_r;
    res_ok_nxt  = res_ok_r;

    tbl_addr             = idx_r;
    tbl_wdata            = sp_r;
    tbl_ctrl.state_we    = 1'b0;
    tbl_ctrl.state_wdata = rrcs_pkg::ST_RUNNING;
    tbl_ctrl.ptr_we      = 1'b0;
    tbl_ctrl.ptr_re      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt = action;
          sp_nxt  = stack_pointer;
          cnt_nxt = '0;
          idx_nxt = '0;
          if (action == rrcs_pkg::ACT_CREATE) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_SAVE;
          end
        end
      end

      S_SAVE: begin
        // save the interrupted pointer and demote the running slot
        tbl_addr             = cur_r;
        tbl_ctrl.ptr_we      = 1'b1;
        tbl_ctrl.state_we    = (tbl_state == rrcs_pkg::ST_RUNNING);
        tbl_ctrl.state_wdata = rrcs_pkg::ST_READY;
        idx_nxt              = (cur_r == SW'(SLOTS - 1)) ? '0 : cur_r + SW'(1);
        cnt_nxt              = '0;
        state_nxt            = S_SCAN;
      end

      S_SCAN: begin
        if (act_r == rrcs_pkg::ACT_CREATE) begin
          if (match) begin
            // claim the lowest unused slot
            tbl_ctrl.ptr_we      = 1'b1;
            tbl_ctrl.state_we    = 1'b1;
            tbl_ctrl.state_wdata = rrcs_pkg::ST_READY;
            res_ptr_nxt          = '0;
            res_idx_nxt          = idx_r;
            res_ok_nxt           = 1'b1;
            state_nxt            = S_OUT;
          end else if (last) begin
            res_ptr_nxt = '0;
            res_idx_nxt = '0;
            res_ok_nxt  = 1'b0;
            state_nxt   = S_OUT;
          end else begin
            idx_nxt = idx_inc;
            cnt_nxt = cnt_r + SW'(1);
          end
        end else begin
          if (match) begin
            state_nxt = S_PICK;
          end else if (last) begin
            // scan ends on the current slot; fall back to slot 0 if unused
            if (tbl_state == rrcs_pkg::ST_UNUSED) begin
              idx_nxt = '0;
            end
            state_nxt = S_PICK;
          end else begin
            idx_nxt = idx_inc;
            cnt_nxt = cnt_r + SW'(1);
          end
        end
      end

      S_PICK: begin
        // make the chosen slot running and fetch its pointer
        tbl_ctrl.state_we    = 1'b1;
        tbl_ctrl.state_wdata = rrcs_pkg::ST_RUNNING;
        tbl_ctrl.ptr_re      = 1'b1;
        cur_nxt              = idx_r;
        state_nxt            = S_FETCH;
      end

      S_FETCH: begin
        res_ptr_nxt = tbl_ptr;
        res_idx_nxt = idx_r;
        res_ok_nxt  = 1'b1;
        state_nxt   = S_OUT;
      end

      S_OUT: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold sequencer state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
    end
    act_r     <= act_nxt;
    sp_r      <= sp_nxt;
    idx_r     <= idx_nxt;
    cnt_r     <= cnt_nxt;
    res_ptr_r <= res_ptr_nxt;
    res_idx_r <= res_idx_nxt;
    res_ok_r  <= res_ok_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res_ptr   = res_ptr_r;
  assign res_idx   = res_idx_r;
  assign res_ok    = res_ok_r;

endmodule

`default_nettype wire

// File: rtl/core/round_robin_context_scheduler_top.sv
// Top level of the round-robin context scheduler.
//
// Input channel (in_valid / in_stall): in_action selects a timer tick (switch
// threads) or a thread create; in_stack_pointer is the interrupted thread's
// stack pointer or the new thread's initial one. One transaction is taken at
// a time; in_stall stays high while a transaction is being worked on.
// Result channel (out_valid / out_stall): one transaction per input, giving
// the chosen or claimed slot, its saved stack pointer (zero for create) and a
// success flag (low only when a create finds no unused slot).
// Operation: the slot table is scanned one slot per cycle by a shared compare
// and index unit. A create scans and then gives its result; a tick goes
// through save, scan, pick, pointer fetch and result. A new transaction is
// taken only once the result of the last one is in the output register.
// Reset (rst_n low, synchronous) makes slot 0 running and current and all
// other slots unused; saved stack pointers are not cleared.
// A stalled result is held in the output register; the next input can be
// taken and worked on meanwhile, and its result waits until the register
// drains.
`default_nettype none

module round_robin_context_scheduler_top #(
  parameter int SLOTS = rrcs_pkg::SLOTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic                                in_action,
  input  wire logic [rrcs_pkg::PTR_W-1:0]          in_stack_pointer,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic [rrcs_pkg::PTR_W-1:0]          out_result_pointer,
  output      logic [rrcs_pkg::OUT_IDX_W-1:0]      out_slot_index,
  output      logic                                out_success
);

  localparam int SW = $clog2(SLOTS);
  localparam int EW = SW + rrcs_pkg::OUT_IDX_W;

  logic                          idle;
  logic                          start;
  logic [SW-1:0]                 tbl_addr;
  rrcs_pkg::tbl_ctrl_t           tbl_ctrl;
  logic [rrcs_pkg::PTR_W-1:0]    tbl_wdata;
  rrcs_pkg::slot_state_t         tbl_state;
  logic [rrcs_pkg::PTR_W-1:0]    tbl_ptr;
  logic                          res_valid;
  logic                          res_take;
  logic [rrcs_pkg::PTR_W-1:0]    res_ptr;
  logic [SW-1:0]                 res_idx;
  logic                          res_ok;
  logic [EW-1:0]                 res_idx_ext;

  logic                              out_valid_r;
  logic [rrcs_pkg::PTR_W-1:0]        out_ptr_r;
  logic [rrcs_pkg::OUT_IDX_W-1:0]    out_idx_r;
  logic                              out_ok_r;

  // Take a new transaction only when the sequencer is idle
  assign in_stall = !idle;
  assign start    = in_valid && !in_stall;

  rrcs_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .action        (in_action),
    .stack_pointer (in_stack_pointer),
    .idle          (idle),
    .tbl_addr      (tbl_addr),
    .tbl_ctrl      (tbl_ctrl),
    .tbl_wdata     (tbl_wdata),
    .tbl_state     (tbl_state),
    .tbl_ptr       (tbl_ptr),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res_ptr       (res_ptr),
    .res_idx       (res_idx),
    .res_ok        (res_ok)
  );

  rrcs_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .addr        (tbl_addr),
    .ctrl        (tbl_ctrl),
    .ptr_wdata   (tbl_wdata),
    .state_rdata (tbl_state),
    .ptr_rdata   (tbl_ptr)
  );

  // Widen the slot index so it can be cut to the result field width
  assign res_idx_ext = EW'(res_idx);

  // Load the output register when it is empty or draining
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      out_ptr_r <= res_ptr;
      out_idx_r <= res_idx_ext[rrcs_pkg::OUT_IDX_W-1:0];
      out_ok_r  <= res_ok;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_pointer = out_ptr_r;
  assign out_slot_index     = out_idx_r;
  assign out_success        = out_ok_r;

endmodule

`default_nettype wire

// File: rtl/core/rrcs_checker.sv
// Port-level checker for the scheduler top level, with its bind.
`default_nettype none

module rrcs_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [rrcs_pkg::PTR_W-1:0]        out_result_pointer,
  input wire logic [rrcs_pkg::OUT_IDX_W-1:0]    out_slot_index,
  input wire logic                              out_success
);

  // A stalled result transaction holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_pointer)
      && $stable(out_slot_index) && $stable(out_success))
    else $error("stalled result changed");

  // A failed create reports slot zero and a zero pointer
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_success |-> out_slot_index == '0 && out_result_pointer == '0)
    else $error("failed create carries non-zero fields");

  // An accepted transaction keeps the input busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind round_robin_context_scheduler_top rrcs_checker u_rrcs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_result_pointer (out_result_pointer),
  .out_slot_index     (out_slot_index),
  .out_success        (out_success)
);

`default_nettype wire

// File: tb/tb_round_robin_context_scheduler_top.sv
// Self-checking testbench for the round-robin context scheduler top level.
`default_nettype none

module tb_round_robin_context_scheduler_top;
  import rrcs_pkg::*;

  localparam int SLOTS      = SLOTS_DEF;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = 4 * SLOTS + 20;
  localparam int RAND_JOBS  = 1130;

  typedef struct packed {
    logic             action;
    logic [PTR_W-1:0] sp;
  } sched_job_t;

  typedef struct packed {
    logic [PTR_W-1:0]     ptr;
    logic [OUT_IDX_W-1:0] idx;
    logic                 ok;
  } sched_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_action = ACT_TICK;
  logic [PTR_W-1:0]     in_stack_pointer = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PTR_W-1:0]     out_result_pointer;
  logic [OUT_IDX_W-1:0] out_slot_index;
  logic                 out_success;

  // Shadow of the slot table
  slot_state_t      thread_state [SLOTS];
  logic [PTR_W-1:0] thread_sp [SLOTS];
  int               thread_cur;

  sched_job_t    pending_jobs[$];
  sched_result_t due_results[$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  int  in_gap = 0;
  int  out_hold = 0;
  bit  in_calm = 1'b0;
  bit  out_calm = 1'b0;

  round_robin_context_scheduler_top #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_stack_pointer  (in_stack_pointer),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_pointer(out_result_pointer),
    .out_slot_index    (out_slot_index),
    .out_success       (out_success)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bring the shadow table to its post-reset state
  task automatic reset_threads();
    for (int i = 0; i < SLOTS; i++) begin
      thread_state[i] = ST_UNUSED;
      thread_sp[i]    = '0;
    end
    thread_state[0] = ST_RUNNING;
    thread_cur      = 0;
  endtask

  // Apply one transaction to the shadow table and return what the block should answer
  function automatic sched_result_t schedule_job(sched_job_t job);
    sched_result_t res;
    int            cur;
    int            idx;
    int            pick;
    res  = '0;
    pick = -1;
    if (job.action == ACT_CREATE) begin
      // Claim the lowest unused slot
      for (int i = 0; i < SLOTS; i++) begin
        if (pick < 0 && thread_state[i] == ST_UNUSED) pick = i;
      end
      if (pick >= 0) begin
        thread_sp[pick]    = job.sp;
        thread_state[pick] = ST_READY;
        res.idx            = pick[OUT_IDX_W-1:0];
        res.ok             = 1'b1;
      end
    end else begin
      // Save and demote the interrupted thread
      cur            = thread_cur;
      thread_sp[cur] = job.sp;
      if (thread_state[cur] == ST_RUNNING) thread_state[cur] = ST_READY;
      // Scan from the next slot, current one last
      idx = cur;
      for (int i = 0; i < SLOTS; i++) begin
        idx = (idx + 1) % SLOTS;
        if (pick < 0 && thread_state[idx] == ST_READY) pick = idx;
      end
      if (pick >= 0) begin
        cur = pick;
      end else if (thread_state[cur] == ST_UNUSED) begin
        cur = 0;
      end
      thread_cur        = cur;
      thread_state[cur] = ST_RUNNING;
      res.ptr           = thread_sp[cur];
      res.idx           = cur[OUT_IDX_W-1:0];
      res.ok            = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [PTR_W-1:0] want, logic [PTR_W-1:0] got);
    $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $time);
    mismatches++;
  endtask

  // Mostly short gaps, a few long ones; none while calm
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PTR_W-1:0] pick_sp();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Driver: present pending transactions, hold while stalled
  always @(posedge clk) begin
    if (rst_n) begin
      if ($urandom_range(0, 299) == 0) in_calm = ~in_calm;
      if (in_valid && !in_stall) begin
        due_results.push_back(schedule_job('{action: in_action, sp: in_stack_pointer}));
        in_gap = pick_gap(in_calm);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_jobs.size() > 0) begin
          in_valid         <= 1'b1;
          in_action        <= pending_jobs[0].action;
          in_stack_pointer <= pending_jobs[0].sp;
          void'(pending_jobs.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction, then decide the next stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result", '0, out_result_pointer);
        end else begin
          if (out_result_pointer !== due_results[0].ptr)
            report_mismatch("result_pointer", due_results[0].ptr, out_result_pointer);
          if (out_slot_index !== due_results[0].idx)
            report_mismatch("slot_index", due_results[0].idx, out_slot_index);
          if (out_success !== due_results[0].ok)
            report_mismatch("success", due_results[0].ok, out_success);
          void'(due_results.pop_front());
        end
      end
      if ($urandom_range(0, 299) == 0) out_calm = ~out_calm;
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_hold = pick_gap(out_calm);
        out_stall <= (out_hold > 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    reset_threads();

    // Ticks with no other thread: slot 0 keeps running, pointer extremes
    pending_jobs.push_back('{action: ACT_TICK,   sp: '0});
    pending_jobs.push_back('{action: ACT_TICK,   sp: '1});
    pending_jobs.push_back('{action: ACT_CREATE, sp: '1});
    pending_jobs.push_back('{action: ACT_CREATE, sp: '0});
    pending_jobs.push_back('{action: ACT_TICK,   sp: 32'h8000_0001});
    pending_jobs.push_back('{action: ACT_TICK,   sp: 32'h5555_5555});
    pending_jobs.push_back('{action: ACT_TICK,   sp: 32'hAAAA_AAAA});
    pending_jobs.push_back('{action: ACT_TICK,   sp: 32'h0000_FFFF});
    // Fill every remaining slot, then try twice more with the table full
    for (int i = 0; i < SLOTS - 3; i++)
      pending_jobs.push_back('{action: ACT_CREATE, sp: $urandom});
    pending_jobs.push_back('{action: ACT_CREATE, sp: '1});
    pending_jobs.push_back('{action: ACT_CREATE, sp: '0});
    // Walk the full ring so every slot index comes out
    for (int i = 0; i < SLOTS + 1; i++)
      pending_jobs.push_back('{action: ACT_TICK, sp: $urandom});

    // Random mix, mostly context switches
    for (int i = 0; i < RAND_JOBS; i++)
      pending_jobs.push_back('{action: ($urandom_range(0, 9) == 0) ? ACT_CREATE : ACT_TICK,
                               sp: pick_sp()});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all sent, all answered, then let the block settle
    do @(posedge clk);
    while (pending_jobs.size() > 0 || in_valid || due_results.size() > 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (due_results.size() > 0)
      report_mismatch("missing results", due_results.size(), '0);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
